// ===== src/sorted_insert_buffer_defines.svh =====
// assertion macros shared by the sorted insert buffer checker
`ifndef SORTED_INSERT_BUFFER_DEFINES_SVH
`define SORTED_INSERT_BUFFER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SIB_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sorted insert buffer check failed");

// next-cycle implication, disabled during reset
`define SIB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sorted insert buffer check failed");

`endif

// ===== src/sib_pkg.sv =====
// shared types and constants of the sorted insert buffer
`default_nettype none

package sib_pkg;

  localparam int unsigned WORD_W = 32;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic one_left;
    logic out_valid;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/sorted_insert_buffer.sv =====
// Sorted insert buffer: keeps up to DEPTH signed 32-bit values in ascending
// order in a row of compare-and-shift cells. While filling, one word is
// accepted per cycle; each is placed just before the first stored value
// that is strictly greater, so equal values keep arrival order. A word
// arriving while the row is full is dropped and sets a sticky overflow flag.
// The word marked with tlast is inserted like any other and then starts the
// readout: N stored values leave in ascending order, one per cycle while
// out_tready is high, the final one with tlast and all of them with the
// overflow flag in tuser. in_tready is low from the edge that takes the last
// word until the final value has moved into the output register. The single
// cell row either takes one insert or, while out_tready is high, shifts out
// one value per cycle. Store and flag are empty again after the readout.
`default_nettype none

module sorted_insert_buffer #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic        in_tlast,   // last_in
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] sorted_value
  output logic             out_tlast,  // last_out
  output logic [0:0]       out_tuser   // [0] overflow
);
  import sib_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ovf;

  sib_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sib_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .out_tready (out_tready),
    .out_value  (out_tdata),
    .out_last   (out_tlast),
    .out_ovf    (ovf),
    .sts        (sts)
  );

  assign out_tvalid   = sts.out_valid;
  assign out_tuser[0] = ovf;

endmodule

`default_nettype wire

// ===== src/sib_ctrl.sv =====
// controller state machine: fill phase and readout phase
`default_nettype none

module sib_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tlast,
  output logic               in_tready,
  input  wire logic          out_tready,
  input  wire sib_pkg::sts_t sts,
  output sib_pkg::cmd_t      cmd
);
  import sib_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // handshake and commands
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    cmd.ins_en = (state_r == ST_IDLE) && in_tvalid;
    cmd.pop_en = (state_r == ST_DRAIN) && (!sts.out_valid || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.ins_en && in_tlast) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (cmd.pop_en && sts.one_left) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/sib_dp.sv =====
// datapath: row of compare-and-shift cells, counters and output register
`default_nettype none

module sib_dp #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [sib_pkg::WORD_W-1:0] in_value,
  input  wire sib_pkg::cmd_t              cmd,
  input  wire logic                       out_tready,
  output logic [sib_pkg::WORD_W-1:0]      out_value,
  output logic                            out_last,
  output logic                            out_ovf,
  output sib_pkg::sts_t                   sts
);
  import sib_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] store_r   [DEPTH];
  logic [WORD_W-1:0] store_nxt [DEPTH];
  logic [DEPTH-1:0]  occ;
  logic [DEPTH-1:0]  gt;
  logic [CNT_W-1:0]  count_r;
  logic              flag_r;
  logic              full;
  logic [WORD_W-1:0] out_value_r;
  logic              out_last_r;
  logic              out_ovf_r;
  logic              out_valid_r;

  assign full         = (count_r == CNT_W'(DEPTH));
  assign sts.one_left  = (count_r == CNT_W'(1));
  assign sts.out_valid = out_valid_r;

  // per-cell compare, shift and place
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic shift;
    logic place;

    assign occ[k] = (CNT_W'(k) < count_r);
    assign gt[k]  = occ[k] && ($signed(store_r[k]) > $signed(in_value));

    if (k == 0) begin : g_first
      assign shift = 1'b0;
    end else begin : g_rest
      // cell moves up when the insert point lies below it
      assign shift = gt[k-1] || !occ[k-1];
    end

    // first cell that is greater, or the first free one
    assign place = (gt[k] || !occ[k]) && !shift;

    always_comb begin
      store_nxt[k] = store_r[k];
      if (cmd.ins_en && !full) begin
        if (shift) begin
          store_nxt[k] = (k == 0) ? in_value : store_r[(k == 0) ? 0 : k-1];
        end else if (place) begin
          store_nxt[k] = in_value;
        end
      end else if (cmd.pop_en) begin
        if (k < DEPTH - 1) begin
          store_nxt[k] = store_r[(k < DEPTH - 1) ? k+1 : k];
        end
      end
    end

    always_ff @(posedge clk) begin
      store_r[k] <= store_nxt[k];
    end
  end

  // entry count and sticky drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      flag_r  <= 1'b0;
    end else if (cmd.ins_en) begin
      if (full) begin
        flag_r <= 1'b1;
      end else begin
        count_r <= count_r + CNT_W'(1);
      end
    end else if (cmd.pop_en) begin
      count_r <= count_r - CNT_W'(1);
      if (sts.one_left) begin
        flag_r <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pop_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_en) begin
      out_value_r <= store_r[0];
      out_last_r  <= sts.one_left;
      out_ovf_r   <= flag_r;
    end
  end

  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

endmodule

`default_nettype wire

// ===== src/sib_checker.sv =====
// port-level checks of the sorted insert buffer and their bind
`default_nettype none

`include "sorted_insert_buffer_defines.svh"

module sib_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [0:0]  out_tuser
);

  logic out_stall;
  logic out_take;

  // output handshake shorthands
  assign out_stall = out_tvalid && !out_tready;
  assign out_take  = out_tvalid && out_tready;

  // a stalled word holds
  `SIB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // the last input word starts the readout
  `SIB_ASSERT_NEXT(a_drain_start, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready)

  // readout words follow each other without gaps
  `SIB_ASSERT_NEXT(a_no_gap, clk, rst_n, out_take && !out_tlast, out_tvalid && $stable(out_tuser))

  // no input is taken in the middle of a readout
  `SIB_ASSERT_NOW(a_no_input, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

endmodule

bind sorted_insert_buffer sib_checker u_sib_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== verif/tb_sorted_insert_buffer.sv =====
// testbench for sorted_insert_buffer: directed and random runs against an ordered-store predictor
`timescale 1ns / 1ps

module tb_sorted_insert_buffer;

  localparam int DEPTH = 32;
  localparam int TOTAL_WORDS = 460;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;

  // one readout word as the block should emit it
  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        ovf;
  } readout_t;

  // directed stimulus row; typed rows carry their single readout word
  typedef struct {
    logic [31:0] value;
    logic        last;
    bit          typed;
    logic [31:0] exp_value;
    logic        exp_last;
    logic        exp_ovf;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;        // [31:0] value
  logic        in_tlast = 1'b0;      // last_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [31:0] sorted_value
  logic        out_tlast;            // last_out
  logic [0:0]  out_tuser;            // [0] overflow

  // typed expectation travelling alongside the driven word
  bit          row_typed = 1'b0;
  logic [31:0] row_exp_value = '0;
  logic        row_exp_last = 1'b0;
  logic        row_exp_ovf = 1'b0;

  // predictor state
  logic signed [31:0] shadow_store [DEPTH];
  int                 shadow_count = 0;
  logic               shadow_dropped = 1'b0;
  readout_t           pending_readout [$];

  int errors = 0;
  int results_seen = 0;
  int words_sent = 0;
  int frames_sent = 0;
  int overflow_words = 0;
  int input_stalls = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit long_hold_done = 1'b0;

  row_t directed_rows [24] = '{
    '{32'd5,        1'b1, 1'b1, 32'd5,        1'b1, 1'b0},
    '{32'h80000000, 1'b1, 1'b1, 32'h80000000, 1'b1, 1'b0},
    '{32'h7fffffff, 1'b1, 1'b1, 32'h7fffffff, 1'b1, 1'b0},
    '{32'd0,        1'b1, 1'b1, 32'd0,        1'b1, 1'b0},
    '{32'hffffffff, 1'b1, 1'b1, 32'hffffffff, 1'b1, 1'b0},
    '{32'd7,        1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'hfffffffd, 1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd7,        1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'h7fffffff, 1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'h80000000, 1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'hffffffff, 1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd0,        1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd7,        1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd2,        1'b1, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd50,       1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd40,       1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd30,       1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd20,       1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd10,       1'b1, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd1,        1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd2,        1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd3,        1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd3,        1'b0, 1'b0, 32'd0,        1'b0, 1'b0},
    '{32'd4,        1'b1, 1'b0, 32'd0,        1'b0, 1'b0}
  };

  sorted_insert_buffer #(
    .DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // place one accepted word in the shadow store; on last, queue the readout
  function automatic void place_word(logic signed [31:0] v, logic last, bit typed,
                                     readout_t typed_word);
    int pos;
    readout_t r;
    if (shadow_count >= DEPTH) begin
      shadow_dropped = 1'b1;
    end else begin
      pos = shadow_count;
      for (int k = 0; k < shadow_count; k++) begin
        if (shadow_store[k] > v) begin
          pos = k;
          break;
        end
      end
      for (int k = shadow_count; k > pos; k--) shadow_store[k] = shadow_store[k - 1];
      shadow_store[pos] = v;
      shadow_count++;
    end
    if (last) begin
      if (typed) begin
        pending_readout.push_back(typed_word);
      end else begin
        for (int k = 0; k < shadow_count; k++) begin
          r.value = shadow_store[k];
          r.last  = (k == shadow_count - 1);
          r.ovf   = shadow_dropped;
          pending_readout.push_back(r);
        end
      end
      shadow_count = 0;
      shadow_dropped = 1'b0;
    end
  endfunction

  // watch both channels: predict on accepted input, check accepted output
  always @(posedge clk) begin : watch
    readout_t want;
    if (rst_n) begin
      if (in_tvalid && !in_tready) input_stalls++;
      if (in_tvalid && in_tready)
        place_word(in_tdata, in_tlast, row_typed, {row_exp_value, row_exp_last, row_exp_ovf});
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tuser[0]) overflow_words++;
        if (pending_readout.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h last %b ovf %b", $time, out_tdata, out_tlast,
                   out_tuser[0]);
        end else begin
          want = pending_readout.pop_front();
          if (out_tdata !== want.value) begin
            errors++;
            $display("%0t: sorted_value expected %h actual %h", $time, want.value, out_tdata);
          end
          if (out_tlast !== want.last) begin
            errors++;
            $display("%0t: last_out expected %b actual %b", $time, want.last, out_tlast);
          end
          if (out_tuser[0] !== want.ovf) begin
            errors++;
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, out_tuser[0]);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_readout.size());
      $display("FAIL sorted_insert_buffer");
      $finish;
    end
  end

  // receiver: segments of differing stall patterns, plus one long hold mid-readout
  initial begin : receiver
    int seg_left;
    int mode;
    seg_left = 0;
    mode = 0;
    forever begin
      if (!long_hold_done && results_seen >= 40 && out_tvalid) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 48);
          mode = $urandom_range(0, 3);
        end
        seg_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) < 7);
          2: out_tready <= seg_left[0];
          default: out_tready <= ($urandom_range(0, 9) < 3);
        endcase
        @(posedge clk);
      end
    end
  end

  // offer one word, with bursty gaps in front of it; returns at the accepting edge
  task automatic send_word(logic [31:0] v, logic last, bit typed, logic [31:0] ev,
                           logic el, logic eo);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid     <= 1'b1;
    in_tdata      <= v;
    in_tlast      <= last;
    row_typed     <= typed;
    row_exp_value <= ev;
    row_exp_last  <= el;
    row_exp_ovf   <= eo;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    words_sent++;
    if (last) frames_sent++;
  endtask

  // stop offering and wait until every queued readout word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_readout.size() != 0) @(posedge clk);
  endtask

  // random value: mostly full range, some clustered for ties, some extremes
  function automatic logic [31:0] pick_value();
    logic [31:0] corners [4] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 16) - 8;
      1: return corners[$urandom_range(0, 3)];
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int len;
    int frame_no;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (directed_rows[i])
      send_word(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].exp_value, directed_rows[i].exp_last,
                directed_rows[i].exp_ovf);
    wait_drained();

    // random frames: exactly full, last dropped when full, two overflow depths, then mixed sizes
    frame_no = 0;
    while (words_sent < TOTAL_WORDS) begin
      case (frame_no)
        0: len = DEPTH;
        1: len = DEPTH + 1;
        2: len = DEPTH + 8;
        3: len = 2 * DEPTH;
        default: len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 12);
      endcase
      for (int k = 0; k < len; k++)
        send_word(pick_value(), k == len - 1, 1'b0, '0, 1'b0, 1'b0);
      frame_no++;
      if (frame_no == 12) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_readout.size() != 0) begin
      errors++;
      $display("%0t: %0d readout words never arrived", $time, pending_readout.size());
    end

    $display("covered %0d input words in %0d frames, %0d readout words checked",
             words_sent, frames_sent, results_seen);
    $display("%0d words carried overflow, %0d input stall cycles, %0d mismatches",
             overflow_words, input_stalls, errors);
    if (errors == 0) begin
      $display("PASS sorted_insert_buffer");
    end else begin
      $display("FAIL sorted_insert_buffer");
    end
    $finish;
  end

endmodule
